// ===== hw/rtl/wgas_pkg.sv =====
// Shared types and constants for the weighted graph adjacency store.
// Holds the beat layouts, the status codes and the operation codes.
// No dependencies.
package wgas_pkg;

  localparam int NAME_W       = 8;
  localparam int WEIGHT_W     = 16;
  localparam int STATUS_W     = 3;
  localparam int NODES_HELD_W = 5;
  localparam int EDGES_HELD_W = 7;

  // Input tdata layout, lowest field first.
  localparam int NEW_LSB    = 0;
  localparam int ORG_LSB    = NEW_LSB + NAME_W;
  localparam int TGT_LSB    = ORG_LSB + NAME_W;
  localparam int WGT_LSB    = TGT_LSB + NAME_W;
  localparam int IN_DATA_W  = WGT_LSB + WEIGHT_W;

  // Output tdata layout, padded to whole bytes.
  localparam int OUT_USED_W = STATUS_W + NODES_HELD_W + EDGES_HELD_W;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK          = 3'd0;
  localparam status_t ST_NODE_EXISTS = 3'd1;
  localparam status_t ST_NO_ENDPOINT = 3'd2;
  localparam status_t ST_EDGE_EXISTS = 3'd3;
  localparam status_t ST_FULL        = 3'd4;

  localparam logic FUNC_NODE = 1'b0;
  localparam logic FUNC_EDGE = 1'b1;

endpackage

// ===== hw/rtl/weighted_graph_adjacency_store_top.sv =====
// Each item runs a node scan over the held nodes; an edge insert whose endpoints are both found
// then runs an edge scan over the held edges, and a done state loads the result beat.
// Throughput: one item at a time; the next input beat is taken at the earliest on the edge that
// takes the result. Input is taken while a result waits. Reset (rst_n low, synchronous) clears
// the counts, not the memories.
module weighted_graph_adjacency_store_top #(
  parameter int MAX_NODES = 16,
  parameter int MAX_EDGES = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // new_name[7:0], origin_name[15:8], target_name[23:16], edge_weight[39:24]
  input  logic [wgas_pkg::IN_DATA_W-1:0]   in_tdata,
  // func[0]
  input  logic [0:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status[2:0], nodes_held[7:3], edges_held[14:8], zero[15]
  output logic [wgas_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import wgas_pkg::*;

  localparam int NIW = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int EIW = $clog2(MAX_EDGES);
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int EW  = 2 * NIW + WEIGHT_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_NSCAN = 2'd1;
  localparam logic [1:0] S_ESCAN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [NAME_W-1:0] node_mem [MAX_NODES];
  logic [EW-1:0]     edge_mem [MAX_EDGES];

  logic [1:0]               state_r;
  logic                     func_r;
  logic [NAME_W-1:0]        new_r, org_r, tgt_r;
  logic signed [WEIGHT_W-1:0] wgt_r;
  logic [NCW-1:0]           node_total_r;
  logic [ECW-1:0]           edge_total_r;
  logic [NCW-1:0]           naddr_r;
  logic                     nvld_r;
  logic [NIW-1:0]           nidx_r;
  logic [NAME_W-1:0]        node_rd_r;
  logic                     new_hit_r, org_hit_r, tgt_hit_r;
  logic [NIW-1:0]           org_idx_r, tgt_idx_r;
  logic [ECW-1:0]           eaddr_r;
  logic                     evld_r;
  logic [2*NIW-1:0]         edge_rd_r;
  logic                     edge_hit_r;
  status_t                  status_r;
  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;

  logic accept, n_issue, n_done, e_issue, e_done;
  logic node_full, edge_full, node_we, edge_we, out_load;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign n_issue    = (naddr_r < node_total_r);
  assign n_done     = !n_issue && !nvld_r;
  assign e_issue    = (eaddr_r < edge_total_r);
  assign e_done     = !e_issue && !evld_r;
  assign node_full  = (node_total_r == NCW'(MAX_NODES));
  assign edge_full  = (edge_total_r == ECW'(MAX_EDGES));
  assign node_we    = (state_r == S_NSCAN) && n_done && (func_r == FUNC_NODE) &&
                      !new_hit_r && !node_full;
  assign edge_we    = (state_r == S_ESCAN) && e_done && !edge_hit_r && !edge_full;
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Tables and payload; the read data is registered, so each compare trails its address.
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_total_r[NIW-1:0]] <= new_r;
    end
    node_rd_r <= node_mem[naddr_r[NIW-1:0]];
    if (edge_we) begin
      edge_mem[edge_total_r[EIW-1:0]] <= {org_idx_r, tgt_idx_r, wgt_r};
    end
    edge_rd_r <= edge_mem[eaddr_r[EIW-1:0]][EW-1:WEIGHT_W];
    if (accept) begin
      func_r <= in_tuser[0];
      new_r  <= in_tdata[NEW_LSB +: NAME_W];
      org_r  <= in_tdata[ORG_LSB +: NAME_W];
      tgt_r  <= in_tdata[TGT_LSB +: NAME_W];
      wgt_r  <= in_tdata[WGT_LSB +: WEIGHT_W];
    end
    if (out_load) begin
      out_data_r <= {{OUT_PAD_W{1'b0}}, EDGES_HELD_W'(edge_total_r),
                     NODES_HELD_W'(node_total_r), status_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_total_r <= '0;
      edge_total_r <= '0;
      naddr_r      <= '0;
      nvld_r       <= 1'b0;
      nidx_r       <= '0;
      new_hit_r    <= 1'b0;
      org_hit_r    <= 1'b0;
      tgt_hit_r    <= 1'b0;
      org_idx_r    <= '0;
      tgt_idx_r    <= '0;
      eaddr_r      <= '0;
      evld_r       <= 1'b0;
      edge_hit_r   <= 1'b0;
      status_r     <= ST_OK;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            naddr_r    <= '0;
            nvld_r     <= 1'b0;
            eaddr_r    <= '0;
            evld_r     <= 1'b0;
            new_hit_r  <= 1'b0;
            org_hit_r  <= 1'b0;
            tgt_hit_r  <= 1'b0;
            edge_hit_r <= 1'b0;
            state_r    <= S_NSCAN;
          end
        end
        S_NSCAN: begin
          if (n_issue) begin
            naddr_r <= naddr_r + 1'b1;
          end
          nvld_r <= n_issue;
          nidx_r <= naddr_r[NIW-1:0];
          // Stored names are unique, so at most one entry can match each name.
          if (nvld_r) begin
            if (node_rd_r == new_r) begin
              new_hit_r <= 1'b1;
            end
            if (node_rd_r == org_r) begin
              org_hit_r <= 1'b1;
              org_idx_r <= nidx_r;
            end
            if (node_rd_r == tgt_r) begin
              tgt_hit_r <= 1'b1;
              tgt_idx_r <= nidx_r;
            end
          end
          if (n_done) begin
            if (func_r == FUNC_NODE) begin
              state_r <= S_DONE;
              if (new_hit_r) begin
                status_r <= ST_NODE_EXISTS;
              end else if (node_full) begin
                status_r <= ST_FULL;
              end else begin
                status_r     <= ST_OK;
                node_total_r <= node_total_r + 1'b1;
              end
            end else if (!org_hit_r || !tgt_hit_r) begin
              status_r <= ST_NO_ENDPOINT;
              state_r  <= S_DONE;
            end else begin
              state_r <= S_ESCAN;
            end
          end
        end
        S_ESCAN: begin
          if (e_issue) begin
            eaddr_r <= eaddr_r + 1'b1;
          end
          evld_r <= e_issue;
          if (evld_r && (edge_rd_r == {org_idx_r, tgt_idx_r})) begin
            edge_hit_r <= 1'b1;
          end
          if (e_done) begin
            state_r <= S_DONE;
            if (edge_hit_r) begin
              status_r <= ST_EDGE_EXISTS;
            end else if (edge_full) begin
              status_r <= ST_FULL;
            end else begin
              status_r     <= ST_OK;
              edge_total_r <= edge_total_r + 1'b1;
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/wgas_checker.sv =====
// Port-level checks for the weighted graph adjacency store, bound to its top level.
// Depends on wgas_pkg for the status codes and beat widths.
module wgas_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [wgas_pkg::OUT_DATA_W-1:0] out_tdata
);
  import wgas_pkg::*;

  // A result beat that is held back must not change under the consumer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Only the five defined status codes ever leave the block.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[STATUS_W-1:0] == ST_OK ||
                    out_tdata[STATUS_W-1:0] == ST_NODE_EXISTS ||
                    out_tdata[STATUS_W-1:0] == ST_NO_ENDPOINT ||
                    out_tdata[STATUS_W-1:0] == ST_EDGE_EXISTS ||
                    out_tdata[STATUS_W-1:0] == ST_FULL))
    else $error("undefined status code");

  // Items are worked one at a time, so an accepted beat closes the input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in progress");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

endmodule

bind weighted_graph_adjacency_store_top wgas_checker u_wgas_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
